// ===== rtl/ifcrq_pkg.sv =====
// Shared types and constants for the int8 fully connected requantize core.
// Used by the controller, the datapath and the top level; no dependencies.
package ifcrq_pkg;

    localparam int ActW    = 8;
    localparam int OffW    = 9;
    localparam int OutW    = 8;
    localparam int MultW   = 31;
    localparam int ShiftW  = 6;
    localparam int BiasW   = 32;
    localparam int AccW    = 32;
    localparam int OpW     = 10;   // int8 plus a 9 bit offset
    localparam int ProdW   = 2 * OpW;
    localparam int WideW   = 64;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 31;
    localparam int InDataW = 48;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_INPUT_OFFSET   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT_OFFSET  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_OFFSET  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OUT_MULTIPLIER = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OUT_SHIFT      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_CLAMP_MIN      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_CLAMP_MAX      = 3'd6;

    localparam logic [MultW-1:0]         MULT_RESET = 31'h4000_0000;
    localparam logic signed [OutW-1:0]   CLAMP_MIN_RESET = -8'sd128;
    localparam logic signed [OutW-1:0]   CLAMP_MAX_RESET = 8'sd127;

    localparam logic signed [WideW-1:0]  NUDGE_POS = 64'sd1 <<< 30;
    localparam logic signed [WideW-1:0]  NUDGE_NEG = 64'sd1 - (64'sd1 <<< 30);
    localparam logic signed [WideW-1:0]  TRUNC_BIAS = (64'sd1 <<< 31) - 64'sd1;
    localparam logic [4:0]               RSH_MAX = 5'd31;

    typedef enum logic [7:0] {
        ST_MAC   = 8'b0000_0001,
        ST_LAST  = 8'b0000_0010,
        ST_BIAS  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_NUDGE = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_RSH   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic accept;
        logic bias;
        logic mul;
        logic nudge;
        logic div;
        logic rsh;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/ifcrq_ctrl.sv =====
// Sequencer for the requantize core: runs the MAC phase and the requantize steps.
// Depends on ifcrq_pkg; drives the datapath through cmd_t and reads sts_t.
module ifcrq_ctrl
    import ifcrq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MAC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_MAC:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_NUDGE;
            ST_NUDGE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_RSH;
            ST_RSH:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                // hold until the output register can take the item
                if (sts.out_free)
                begin
                    state_next = ST_MAC;
                end
            end
            default:  state_next = ST_MAC;
        endcase
    end

    assign s_tready   = (state_reg == ST_MAC);
    assign cmd.accept = (state_reg == ST_MAC) && s_tvalid;
    assign cmd.bias   = (state_reg == ST_BIAS);
    assign cmd.mul    = (state_reg == ST_MUL);
    assign cmd.nudge  = (state_reg == ST_NUDGE);
    assign cmd.div    = (state_reg == ST_DIV);
    assign cmd.rsh    = (state_reg == ST_RSH);
    assign cmd.emit   = (state_reg == ST_EMIT) && sts.out_free;

endmodule

// ===== rtl/ifcrq_datapath.sv =====
// Datapath of the requantize core: config registers, MAC, requantize steps, output register.
// Depends on ifcrq_pkg; sequenced by ifcrq_ctrl through cmd_t.
module ifcrq_datapath
    import ifcrq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgW-1:0]      cfg_data,
    input  logic [InDataW-1:0]   s_tdata,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata
);

    // configuration
    logic signed [OffW-1:0]   in_off_reg;
    logic signed [OffW-1:0]   wt_off_reg;
    logic signed [OutW-1:0]   out_off_reg;
    logic [MultW-1:0]         mult_reg;
    logic signed [ShiftW-1:0] shift_reg;
    logic signed [OutW-1:0]   cmin_reg;
    logic signed [OutW-1:0]   cmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_off_reg  <= '0;
            wt_off_reg  <= '0;
            out_off_reg <= '0;
            mult_reg    <= MULT_RESET;
            shift_reg   <= '0;
            cmin_reg    <= CLAMP_MIN_RESET;
            cmax_reg    <= CLAMP_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INPUT_OFFSET:   in_off_reg  <= cfg_data[OffW-1:0];
                REG_WEIGHT_OFFSET:  wt_off_reg  <= cfg_data[OffW-1:0];
                REG_OUTPUT_OFFSET:  out_off_reg <= cfg_data[OutW-1:0];
                REG_OUT_MULTIPLIER: mult_reg    <= cfg_data[MultW-1:0];
                REG_OUT_SHIFT:      shift_reg   <= cfg_data[ShiftW-1:0];
                REG_CLAMP_MIN:      cmin_reg    <= cfg_data[OutW-1:0];
                REG_CLAMP_MAX:      cmax_reg    <= cfg_data[OutW-1:0];
                default:            ;
            endcase
        end
    end

    // MAC stage: product registered on accept, summed the cycle after
    logic signed [ActW-1:0]  act;
    logic signed [ActW-1:0]  wt;
    logic signed [OpW-1:0]   act_op;
    logic signed [OpW-1:0]   wt_op;
    logic signed [ProdW-1:0] prod_reg;
    logic                    prod_vld_reg;
    logic [BiasW-1:0]        bias_reg;
    logic [AccW-1:0]         acc_reg;
    logic [AccW-1:0]         acc_next;

    assign act    = s_tdata[7:0];
    assign wt     = s_tdata[15:8];
    assign act_op = OpW'(act) + OpW'(in_off_reg);
    assign wt_op  = OpW'(wt) + OpW'(wt_off_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            prod_reg <= act_op * wt_op;
            bias_reg <= s_tdata[47:16];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.bias)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + AccW'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            prod_vld_reg <= cmd.accept;
        end
    end

    // shift amounts; a right shift of 32 saturates to 31
    logic [4:0]        left_amt;
    logic [ShiftW-1:0] neg_shift;
    logic [4:0]        right_amt;

    assign left_amt  = (!shift_reg[ShiftW-1] && (shift_reg != '0)) ? shift_reg[4:0] : 5'd0;
    assign neg_shift = ShiftW'(~shift_reg + 1'b1);
    assign right_amt = !shift_reg[ShiftW-1] ? 5'd0 :
                       (neg_shift[ShiftW-1] ? RSH_MAX : neg_shift[4:0]);

    // requantize steps
    logic signed [AccW-1:0]  v_reg;
    logic signed [WideW-1:0] mul_reg;
    logic signed [WideW-1:0] nud_reg;
    logic signed [AccW-1:0]  q_reg;
    logic signed [AccW-1:0]  rsh_reg;
    logic [AccW-1:0]         sum_bias;
    logic signed [WideW-1:0] div_sum;
    logic [AccW-1:0]         rmask;
    logic [AccW-1:0]         rem;
    logic [AccW-1:0]         thr;
    logic signed [AccW-1:0]  q_shr;

    assign sum_bias = acc_reg + bias_reg;
    assign div_sum  = nud_reg + (nud_reg[WideW-1] ? TRUNC_BIAS : 64'sd0);
    assign rmask    = (32'd1 << right_amt) - 32'd1;
    assign rem      = q_reg & rmask;
    assign thr      = (rmask >> 1) + AccW'(q_reg[AccW-1]);
    assign q_shr    = q_reg >>> right_amt;

    always_ff @(posedge clk)
    begin
        if (cmd.bias)
        begin
            v_reg <= sum_bias << left_amt;
        end
        if (cmd.mul)
        begin
            mul_reg <= v_reg * $signed({1'b0, mult_reg});
        end
        if (cmd.nudge)
        begin
            nud_reg <= mul_reg + (mul_reg[WideW-1] ? NUDGE_NEG : NUDGE_POS);
        end
        if (cmd.div)
        begin
            // truncate toward zero
            q_reg <= AccW'(div_sum >>> 31);
        end
        if (cmd.rsh)
        begin
            rsh_reg <= q_shr + AccW'(rem > thr);
        end
    end

    // offset and clamp, lower bound first
    logic signed [AccW:0] off_sum;
    logic signed [AccW:0] clamped;

    always_comb
    begin
        off_sum = (AccW+1)'(rsh_reg) + (AccW+1)'(out_off_reg);
        clamped = off_sum;
        if (clamped < (AccW+1)'(cmin_reg))
        begin
            clamped = (AccW+1)'(cmin_reg);
        end
        if (clamped > (AccW+1)'(cmax_reg))
        begin
            clamped = (AccW+1)'(cmax_reg);
        end
    end

    // output register
    logic       out_vld_reg;
    logic [7:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= clamped[7:0];
        end
    end

    assign sts.out_free = !out_vld_reg || m_tready;
    assign m_tvalid     = out_vld_reg;
    assign m_tdata      = out_data_reg;

endmodule

// ===== rtl/int8_fc_channel_requantize_core.sv =====
// Int8 fully connected channel with requantization: top level.
// Depends on ifcrq_pkg, ifcrq_ctrl and ifcrq_datapath.
//
// Items that do not close a dot product are taken one per cycle; the product is
// registered and added into the 32-bit accumulator the cycle after. An item with
// tlast set starts the requantize sequence (last add, bias and left shift, 32x31
// multiply, rounding nudge, divide by 2^31, rounding right shift, offset and
// clamp), and no item is taken until it ends, later still if the output register
// still holds an unread result. That sequence runs on one multiplier and one set of
// registers. The output register lets the next channel start while a result waits.
module int8_fc_channel_requantize_core
    import ifcrq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // config write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // activation[7:0], weight[15:8], bias_value[47:16]
    input  logic                s_tlast,   // last
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata    // out_value[7:0]
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ifcrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ifcrq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a closing item stops intake while the requantize sequence runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("item taken during requantize sequence");

    // an ordinary item keeps intake open
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tlast) |=> s_tready)
        else $error("intake stalled after an ordinary item");

    // a new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result written over a pending item");

endmodule

// ===== test/int8_fc_channel_requantize_core_test.sv =====
// Self-checking bench for int8_fc_channel_requantize_core: a directed table and then
// random dot products, each checked against a predictor of the MAC and requantize path.
// Depends on ifcrq_pkg and the core RTL.
module int8_fc_channel_requantize_core_test;
    import ifcrq_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int HOLD_PHASE    = 6;
    localparam int STEADY_PHASE  = 3;

    localparam logic [CfgIdxW-1:0]    REG_UNUSED = 3'd7;   // no register behind it
    localparam logic signed [31:0]    INT_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]    INT_MIN    = 32'sh8000_0000;

    typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CfgIdxW-1:0]        index;
        logic [CfgW-1:0]           data;
        logic signed [7:0]         act;
        logic signed [7:0]         wt;
        logic signed [31:0]        bias;
        logic                      last;
        logic                      typed;
        logic signed [7:0]         want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [CfgW-1:0]      cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata   = '0;   // activation[7:0], weight[15:8], bias_value[47:16]
    logic                 s_tlast   = 1'b0; // last
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // out_value[7:0]

    // predictor copy of the registers and the accumulator
    logic signed [8:0]    in_off   = '0;
    logic signed [8:0]    wt_off   = '0;
    logic signed [7:0]    out_off  = '0;
    logic [30:0]          mult     = MULT_RESET;
    logic signed [5:0]    shift    = '0;
    logic signed [7:0]    cmin     = CLAMP_MIN_RESET;
    logic signed [7:0]    cmax     = CLAMP_MAX_RESET;
    logic [31:0]          acc_sum  = '0;

    logic signed [7:0]    pending_out_q[$];
    stim_row_t            dir_rows[$];
    int                   mismatch_count = 0;
    bit                   steady     = 1'b0;
    bit                   hold_armed = 1'b0;
    bit                   hold_done  = 1'b0;
    int                   hold_count = 0;

    int8_fc_channel_requantize_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void log_failure(input string msg);
        if (mismatch_count < 10)
            $display("%s", msg);
        mismatch_count++;
    endfunction

    // One MAC step; on a last item also bias, requantize, offset and clamp.
    function automatic bit fc_step(input logic signed [7:0] act, input logic signed [7:0] wt,
                                   input logic signed [31:0] bias, input logic last,
                                   output logic signed [7:0] y);
        int          a;
        int          w;
        int          lsh;
        int unsigned rsh;
        int          v;
        int          q;
        longint      p;
        longint      r;
        int unsigned mask;
        int unsigned rem;
        int unsigned thr;
        a = int'(act) + int'(in_off);
        w = int'(wt) + int'(wt_off);
        acc_sum = acc_sum + 32'(a * w);
        y = '0;
        if (!last)
            return 1'b0;
        acc_sum = acc_sum + bias;
        lsh = (shift > 0) ? int'(shift) : 0;
        rsh = (shift > 0) ? 0 : -int'(shift);
        if (rsh > 31)
            rsh = 31;
        v = int'(acc_sum << lsh);
        // doubling high multiply: round half away, truncate toward zero
        p = longint'(v) * longint'({1'b0, mult});
        p = p + ((p >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30)));
        q = int'(p / (longint'(1) << 31));
        if (rsh != 0)
        begin
            mask = (32'd1 << rsh) - 32'd1;
            rem  = int'(q) & mask;
            thr  = (mask >> 1) + ((q < 0) ? 1 : 0);
            q    = (q >>> rsh) + ((rem > thr) ? 1 : 0);
        end
        r = longint'(q) + longint'(out_off);
        if (r < cmin)
            r = cmin;
        if (r > cmax)
            r = cmax;
        y = r[7:0];
        acc_sum = '0;
        return 1'b1;
    endfunction

    function automatic void add_item(input logic signed [7:0] act, input logic signed [7:0] wt,
                                     input logic signed [31:0] bias, input logic last);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.act   = act;
        row.wt    = wt;
        row.bias  = bias;
        row.last  = last;
        dir_rows.push_back(row);
    endfunction

    // last item whose result is known by inspection
    function automatic void add_checked(input logic signed [7:0] act, input logic signed [7:0] wt,
                                        input logic signed [31:0] bias,
                                        input logic signed [7:0] want);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.act   = act;
        row.wt    = wt;
        row.bias  = bias;
        row.last  = 1'b1;
        row.typed = 1'b1;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CfgIdxW-1:0] index, input int data);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data[CfgW-1:0];
        dir_rows.push_back(row);
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] index, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data[CfgW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_INPUT_OFFSET:   in_off  = data[8:0];
            REG_WEIGHT_OFFSET:  wt_off  = data[8:0];
            REG_OUTPUT_OFFSET:  out_off = data[7:0];
            REG_OUT_MULTIPLIER: mult    = data[30:0];
            REG_OUT_SHIFT:      shift   = data[5:0];
            REG_CLAMP_MIN:      cmin    = data[7:0];
            REG_CLAMP_MAX:      cmax    = data[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic signed [7:0] act, input logic signed [7:0] wt,
                             input logic signed [31:0] bias, input logic last,
                             input logic typed, input logic signed [7:0] want);
        logic signed [7:0] y;
        bit                got;
        while (!steady && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bias, wt, act};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        got = fc_step(act, wt, bias, last, y);
        if (got)
            pending_out_q.push_back(typed ? want : y);
    endtask

    // Drop valid, wait for every result, then let the pipeline empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_setup();
        int lo;
        int hi;
        if ($urandom_range(99) < 70)
        begin
            lo = ($urandom_range(9) == 0) ? 0 : -128 + int'($urandom_range(30));
            hi = 127 - int'($urandom_range(30));
            write_reg(REG_INPUT_OFFSET, int'($urandom_range(255)) - 127);
            write_reg(REG_WEIGHT_OFFSET, ($urandom_range(1) == 0) ? 0
                                         : int'($urandom_range(255)) - 127);
            write_reg(REG_OUTPUT_OFFSET, $urandom);
            write_reg(REG_OUT_MULTIPLIER, $urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
            write_reg(REG_OUT_SHIFT, ($urandom_range(99) < 15) ? int'($urandom_range(3))
                                     : -int'($urandom_range(14, 2)));
            write_reg(REG_CLAMP_MIN, lo);
            write_reg(REG_CLAMP_MAX, hi);
        end
        else
        begin
            // whole field space, inverted clamps and a right shift of 32 included
            write_reg(REG_INPUT_OFFSET, $urandom);
            write_reg(REG_WEIGHT_OFFSET, $urandom);
            write_reg(REG_OUTPUT_OFFSET, $urandom);
            write_reg(REG_OUT_MULTIPLIER, $urandom);
            write_reg(REG_OUT_SHIFT, $urandom);
            write_reg(REG_CLAMP_MIN, $urandom);
            write_reg(REG_CLAMP_MAX, $urandom);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        logic signed [7:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_out_q.size() == 0)
                    log_failure($sformatf("result %0d with none expected", $signed(m_tdata)));
                else
                begin
                    want = pending_out_q.pop_front();
                    if (m_tdata !== want)
                        log_failure($sformatf("out_value expected %0d got %0d",
                                              want, $signed(m_tdata)));
                end
            end
            // one long hold-off so the core fills up and stalls its input
            if (hold_armed && !hold_done)
            begin
                m_tready <= 1'b0;
                hold_count++;
                hold_done = (hold_count >= HOLD_CYCLES);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 20);
        end
    end

    initial
    begin : stimulus
        stim_row_t         row;
        int                rand_items;
        int                target;
        int                phase;
        int                len;
        int                sel;
        logic signed [31:0] bias;

        // reset configuration first
        add_checked(0, 0, 0, 0);
        add_checked(127, 127, 0, 127);
        add_checked(-128, 127, 0, -128);
        add_checked(0, 0, 10, 5);
        add_checked(0, 0, INT_MAX, 127);
        add_checked(0, 0, INT_MIN, -128);
        add_item(-128, -128, 0, 1'b0);
        add_item(127, -128, INT_MIN, 1'b0);
        add_item(1, 1, 0, 1'b0);
        add_item(5, -7, -100, 1'b1);
        // offset extremes, full multiplier, right shift of 32, inverted clamp
        add_write(REG_INPUT_OFFSET, 255);
        add_write(REG_WEIGHT_OFFSET, -256);
        add_write(REG_OUTPUT_OFFSET, -128);
        add_write(REG_OUT_MULTIPLIER, 32'h7FFF_FFFF);
        add_write(REG_OUT_SHIFT, -32);
        add_write(REG_CLAMP_MIN, 127);
        add_write(REG_CLAMP_MAX, -128);
        add_write(REG_UNUSED, -1);
        add_checked(-128, 127, 12345, -128);
        add_item(127, -128, INT_MIN, 1'b1);
        // left shift of 30, wrapping before the multiply
        add_write(REG_CLAMP_MIN, -128);
        add_write(REG_CLAMP_MAX, 127);
        add_write(REG_OUTPUT_OFFSET, 127);
        add_write(REG_OUT_SHIFT, 30);
        add_write(REG_OUT_MULTIPLIER, 32'h4000_0000);
        add_item(3, 5, 7, 1'b1);
        add_item(0, 0, 1, 1'b1);
        add_item(-128, -128, INT_MAX, 1'b1);
        // zero multiplier leaves only the output offset
        add_write(REG_OUT_MULTIPLIER, 0);
        add_write(REG_OUTPUT_OFFSET, 0);
        add_write(REG_OUT_SHIFT, -31);
        add_checked(-1, -1, -5, 0);
        // accumulator and bias wrap
        add_write(REG_WEIGHT_OFFSET, 255);
        add_write(REG_OUT_MULTIPLIER, 32'h4000_0000);
        add_write(REG_OUT_SHIFT, 0);
        add_item(127, 127, 0, 1'b0);
        add_item(127, 127, INT_MAX, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                drain();
                write_reg(row.index, int'(row.data));
            end
            else
                send_item(row.act, row.wt, row.bias, row.last, row.typed, row.want);
        end

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            drain();
            random_setup();
            steady = (phase == STEADY_PHASE);
            if (phase == HOLD_PHASE)
                hold_armed = 1'b1;
            target = rand_items + ((phase == HOLD_PHASE) ? 120 : int'($urandom_range(80, 30)));
            while (rand_items < target)
            begin
                sel = $urandom_range(99);
                len = (sel < 75) ? int'($urandom_range(8, 1)) : int'($urandom_range(40, 9));
                bias = ($urandom_range(99) < 15) ? $urandom
                                                 : int'($urandom_range(131072)) - 65536;
                for (int k = 0; k < len; k++)
                begin
                    // bias on items that do not close the sum is ignored: keep it random
                    send_item(8'($urandom), 8'($urandom), (k == len - 1) ? bias : $urandom,
                              k == len - 1, 1'b0, '0);
                    rand_items++;
                end
            end
            steady = 1'b0;
            phase++;
        end

        drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ifcrq_pkg.sv
rtl/ifcrq_ctrl.sv
rtl/ifcrq_datapath.sv
rtl/int8_fc_channel_requantize_core.sv
test/int8_fc_channel_requantize_core_test.sv
